@@ sv/png_scanline_unfilter_top_defines.svh @@
// Assertion macros shared by the PNG scanline unfilter RTL.
`ifndef PNG_SCANLINE_UNFILTER_TOP_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define PSU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define PSU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/psu_pkg.sv @@
// Package with types, constants and the Paeth predictor of the scanline unfilter.
`default_nettype none
package psu_pkg;

	localparam int MAX_ROW_BYTES_DEF = 4096;
	localparam int LINE_BYTES_W      = 13;
	localparam int BPP_W             = 3;
	localparam int CFG_DATA_W        = 13;
	localparam int BYTE_W            = 8;

	localparam logic [LINE_BYTES_W-1:0] LINE_BYTES_RST = LINE_BYTES_W'(4);
	localparam logic [BPP_W-1:0]        BPP_RST        = BPP_W'(4);

	typedef enum logic [0:0] {
		REG_LINE_BYTES = 1'b0,
		REG_BPP        = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		FLT_NONE  = 3'd0,
		FLT_SUB   = 3'd1,
		FLT_UP    = 3'd2,
		FLT_AVG   = 3'd3,
		FLT_PAETH = 3'd4
	} filter_t;

	localparam logic [BYTE_W-1:0] FLT_MAX_CODE = BYTE_W'(FLT_PAETH);

	typedef struct packed {
		logic [BYTE_W-1:0] pixel_byte;
		logic              bad_filter;
		logic              row_end;
	} result_t;

	function automatic logic [BYTE_W-1:0] paeth(input logic [BYTE_W-1:0] a,
			input logic [BYTE_W-1:0] b, input logic [BYTE_W-1:0] c);
		logic signed [10:0] sa;
		logic signed [10:0] sb;
		logic signed [10:0] sc;
		logic signed [10:0] da;
		logic signed [10:0] db;
		logic signed [10:0] dc;
		logic signed [10:0] pa;
		logic signed [10:0] pb;
		logic signed [10:0] pc;
		sa = signed'({3'b000, a});
		sb = signed'({3'b000, b});
		sc = signed'({3'b000, c});
		da = sb - sc;
		db = sa - sc;
		dc = sa + sb - sc - sc;
		pa = (da < 0) ? -da : da;
		pb = (db < 0) ? -db : db;
		pc = (dc < 0) ? -dc : dc;
		if (pa <= pb && pa <= pc) begin
			return a;
		end else if (pb <= pc) begin
			return b;
		end else begin
			return c;
		end
	endfunction

endpackage
`default_nettype wire

@@ sv/psu_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module psu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ sv/psu_predict.sv @@
// Filter prediction and byte reconstruction for one data byte.
`default_nettype none
module psu_predict (
	input  wire psu_pkg::filter_t              filter,
	input  wire logic [psu_pkg::BYTE_W-1:0]    a,
	input  wire logic [psu_pkg::BYTE_W-1:0]    b,
	input  wire logic [psu_pkg::BYTE_W-1:0]    c,
	input  wire logic [psu_pkg::BYTE_W-1:0]    d,
	output logic      [psu_pkg::BYTE_W-1:0]    r
);
	import psu_pkg::*;

	logic [BYTE_W:0]   sum_ab;
	logic [BYTE_W-1:0] pred;

	assign sum_ab = {1'b0, a} + {1'b0, b};

	always_comb begin
		unique case (filter)
			FLT_SUB:   pred = a;
			FLT_UP:    pred = b;
			FLT_AVG:   pred = sum_ab[BYTE_W:1];
			FLT_PAETH: pred = paeth(a, b, c);
			default:   pred = '0;
		endcase
	end

	assign r = d + pred;

endmodule
`default_nettype wire

@@ sv/psu_core.sv @@
// Row state, history registers, previous-row store and result formation.
`default_nettype none
`include "png_scanline_unfilter_top_defines.svh"
module psu_core #(
	parameter int MAX_ROW_BYTES = psu_pkg::MAX_ROW_BYTES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire psu_pkg::cfg_index_t               cfg_addr,
	input  wire logic [psu_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire logic                              in_valid,
	input  wire logic [psu_pkg::BYTE_W-1:0]        data_byte,
	input  wire logic                              image_start,
	output logic                                   res_valid,
	output psu_pkg::result_t                       res
);
	import psu_pkg::*;

	localparam int AW = $clog2(MAX_ROW_BYTES);
	localparam int CW = $clog2(MAX_ROW_BYTES + 1);
	localparam int LW = (CW > LINE_BYTES_W) ? CW : LINE_BYTES_W;

	logic [LINE_BYTES_W-1:0] line_bytes_q;
	logic [BPP_W-1:0]        bpp_q;
	logic [CW-1:0]           col_q;
	logic [CW-1:0]           col_eff;
	logic [CW-1:0]           col_n;
	filter_t                 filter_q;
	logic                    first_q;
	logic                    first_eff;
	logic [BYTE_W-1:0]       left_q [4];
	logic [BYTE_W-1:0]       upleft_q [4];

	logic [LW-1:0]           lb_ext;
	logic [LW-1:0]           len_lw;
	logic [CW-1:0]           len_eff;
	logic [1:0]              hsel;
	logic                    is_filter;
	logic                    last;
	logic                    bad;
	logic [BYTE_W-1:0]       a;
	logic [BYTE_W-1:0]       b;
	logic [BYTE_W-1:0]       c;
	logic [BYTE_W-1:0]       r;
	logic [BYTE_W-1:0]       prev_byte;
	logic [AW-1:0]           waddr;
	logic [AW-1:0]           raddr;
	logic                    we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_bytes_q <= LINE_BYTES_RST;
			bpp_q        <= BPP_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_LINE_BYTES: line_bytes_q <= cfg_wdata[LINE_BYTES_W-1:0];
				REG_BPP:        bpp_q        <= cfg_wdata[BPP_W-1:0];
			endcase
		end
	end

	assign lb_ext = LW'(line_bytes_q);

	always_comb begin
		if (line_bytes_q == '0) begin
			len_lw = LW'(1);
		end else if (lb_ext > LW'(MAX_ROW_BYTES)) begin
			len_lw = LW'(MAX_ROW_BYTES);
		end else begin
			len_lw = lb_ext;
		end
	end

	assign len_eff = len_lw[CW-1:0];

	always_comb begin
		unique case (bpp_q)
			3'd0, 3'd1: hsel = 2'd0;
			3'd2:       hsel = 2'd1;
			3'd3:       hsel = 2'd2;
			default:    hsel = 2'd3;
		endcase
	end

	assign col_eff   = image_start ? '0 : col_q;
	assign first_eff = image_start | first_q;
	assign is_filter = (col_eff == '0);
	assign last      = !is_filter && (col_eff >= len_eff);
	assign bad       = is_filter && (data_byte > FLT_MAX_CODE);

	assign a = left_q[hsel];
	assign c = upleft_q[hsel];
	assign b = first_eff ? '0 : prev_byte;

	psu_predict u_predict (
		.filter (filter_q),
		.a      (a),
		.b      (b),
		.c      (c),
		.d      (data_byte),
		.r      (r)
	);

	always_comb begin
		if (!in_valid) begin
			col_n = col_q;
		end else if (is_filter) begin
			col_n = CW'(1);
		end else if (last) begin
			col_n = '0;
		end else begin
			col_n = col_eff + CW'(1);
		end
	end

	// prefetch the previous-row byte for the next data beat
	assign raddr = (col_n == '0) ? '0 : AW'(col_n - CW'(1));
	assign waddr = AW'(col_eff - CW'(1));
	assign we    = in_valid && !is_filter;

	psu_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_ROW_BYTES)
	) u_row_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (r),
		.raddr (raddr),
		.rdata (prev_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			filter_q <= FLT_NONE;
			first_q  <= 1'b1;
			for (int k = 0; k < 4; k++) begin
				left_q[k]   <= '0;
				upleft_q[k] <= '0;
			end
		end else if (in_valid) begin
			col_q <= col_n;
			if (is_filter) begin
				first_q  <= first_eff;
				filter_q <= bad ? FLT_NONE : filter_t'(data_byte[2:0]);
				for (int k = 0; k < 4; k++) begin
					left_q[k]   <= '0;
					upleft_q[k] <= '0;
				end
			end else begin
				if (last) begin
					first_q <= 1'b0;
				end
				left_q[0]   <= r;
				upleft_q[0] <= b;
				for (int k = 1; k < 4; k++) begin
					left_q[k]   <= left_q[k-1];
					upleft_q[k] <= upleft_q[k-1];
				end
			end
		end
	end

	assign res_valid      = in_valid && (!is_filter || bad);
	assign res.pixel_byte = is_filter ? '0 : r;
	assign res.bad_filter = is_filter;
	assign res.row_end    = last;

	`PSU_ASSERT_NXT(a_row_wrap, in_valid && last, (col_q == '0) && !first_q, "row end did not rewind column")
	`PSU_ASSERT_NXT(a_start_first, in_valid && image_start, first_q && (col_q == CW'(1)), "image start did not mark first row")
	`PSU_ASSERT_IMP(a_col_bound, 1'b1, col_q <= CW'(MAX_ROW_BYTES), "column beyond row store")

endmodule
`default_nettype wire

@@ sv/psu_out_buf.sv @@
// Two-entry output register with skid stage for result beats.
`default_nettype none
`include "png_scanline_unfilter_top_defines.svh"
module psu_out_buf (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire psu_pkg::result_t in_res,
	output logic                  in_ready,
	output logic                  out_valid,
	output psu_pkg::result_t      out_res,
	input  wire logic             out_ready
);
	import psu_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : in_res;
		end else if (in_valid && !skid_valid_q) begin
			skid_q <= in_res;
		end
	end

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	`PSU_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q, "skid held while output empty")
	`PSU_ASSERT_NXT(a_stall_to_skid, in_valid && out_valid_q && !out_ready, skid_valid_q, "stalled beat not held")
	`PSU_ASSERT_NXT(a_skid_drain, skid_valid_q && out_ready, out_valid_q && !skid_valid_q, "skid beat not moved out")

endmodule
`default_nettype wire

@@ sv/png_scanline_unfilter_top.sv @@
// An accepted data beat's result is registered, in the skid stage if m_* stalls.
// Throughput: one beat per cycle; s_tready drops only while two results wait unsent.
// Filter-type beats give no result unless the type is unknown.
// Reset clears row state, histories and registers (line_bytes 4, bytes_per_pixel 4);
// the row store is not cleared, the first row of an image reads zero instead.
`default_nettype none
module png_scanline_unfilter_top #(
	parameter int MAX_ROW_BYTES = psu_pkg::MAX_ROW_BYTES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire psu_pkg::cfg_index_t            cfg_addr,
	input  wire logic [psu_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [7:0]                     s_tdata,  // data_byte
	input  wire logic                           s_tuser,  // image_start
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [7:0]                          m_tdata,  // pixel_byte
	output logic                                m_tuser,  // bad_filter
	output logic                                m_tlast   // row_end
);
	import psu_pkg::*;

	logic    beat_in;
	logic    res_valid;
	result_t res;
	result_t out_res;

	assign beat_in = s_tvalid && s_tready;

	psu_core #(
		.MAX_ROW_BYTES (MAX_ROW_BYTES)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (beat_in),
		.data_byte   (s_tdata),
		.image_start (s_tuser),
		.res_valid   (res_valid),
		.res         (res)
	);

	psu_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_res    (res),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_res   (out_res),
		.out_ready (m_tready)
	);

	assign m_tdata = out_res.pixel_byte;
	assign m_tuser = out_res.bad_filter;
	assign m_tlast = out_res.row_end;

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for png_scanline_unfilter_top: row-by-row filter reconstruction.
`timescale 1ns / 1ps
module testbench;
	import psu_pkg::*;

	localparam int STORE_DEPTH  = MAX_ROW_BYTES_DEF;
	localparam int LONG_ROW     = 256;
	localparam int RANDOM_BEATS = 600;
	localparam int DRAIN_CYCLES = 4;
	localparam logic [7:0] BAD_FLT_MIN = FLT_MAX_CODE + 8'd1;
	localparam logic [7:0] BAD_FLT_MAX = 8'hFF;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	cfg_index_t            cfg_addr = REG_LINE_BYTES;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [7:0]            m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;

	png_scanline_unfilter_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Mirror of the unfilter state.
	logic [7:0]              row_mem [STORE_DEPTH];
	bit                      row_written [STORE_DEPTH];
	logic [7:0]              left_hist [4];
	logic [7:0]              upleft_hist [4];
	logic [LINE_BYTES_W-1:0] col_cnt;
	filter_t                 cur_filter;
	bit                      first_row;
	logic [LINE_BYTES_W-1:0] cfg_len;
	logic [BPP_W-1:0]        cfg_bpp;

	result_t pixel_q[$];

	bit        tx_idle_en = 1'b1;
	bit        rx_stall_en = 1'b1;
	int        burst_left = 0;
	bit [31:0] stall_mask = '1;
	int        stall_pos = 0;

	int beats_sent = 0;
	int results_seen = 0;
	int rows_seen = 0;
	int bad_seen = 0;
	int reg_writes = 0;
	int err_cnt = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("png_scanline_unfilter_top regression: fail");
		$finish;
	end

	function automatic logic [7:0] paeth_choose(logic [7:0] a, logic [7:0] b, logic [7:0] c);
		int ia;
		int ib;
		int ic;
		int p;
		int da;
		int db;
		int dc;
		ia = a;
		ib = b;
		ic = c;
		p = ia + ib - ic;
		da = (p > ia) ? p - ia : ia - p;
		db = (p > ib) ? p - ib : ib - p;
		dc = (p > ic) ? p - ic : ic - p;
		if (da <= db && da <= dc) begin
			return a;
		end else if (db <= dc) begin
			return b;
		end
		return c;
	endfunction

	function automatic void unfilter_reset();
		for (int k = 0; k < STORE_DEPTH; k++) begin
			row_mem[k] = '0;
			row_written[k] = 1'b0;
		end
		for (int k = 0; k < 4; k++) begin
			left_hist[k] = '0;
			upleft_hist[k] = '0;
		end
		col_cnt = '0;
		cur_filter = FLT_NONE;
		first_row = 1'b1;
		cfg_len = LINE_BYTES_RST;
		cfg_bpp = BPP_RST;
	endfunction

	function automatic void unfilter_beat(logic [7:0] d, logic st);
		int len;
		int bpp;
		int idx;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
		logic [7:0] pred;
		logic [7:0] r;
		bit last;
		len = (cfg_len == 0) ? 1 : ((cfg_len > STORE_DEPTH) ? STORE_DEPTH : cfg_len);
		bpp = (cfg_bpp == 0) ? 1 : ((cfg_bpp > 4) ? 4 : cfg_bpp);
		if (st) begin
			first_row = 1'b1;
			col_cnt = '0;
		end
		if (col_cnt == 0) begin
			for (int k = 0; k < 4; k++) begin
				left_hist[k] = '0;
				upleft_hist[k] = '0;
			end
			col_cnt = LINE_BYTES_W'(1);
			if (d > FLT_MAX_CODE) begin
				cur_filter = FLT_NONE;
				pixel_q.push_back('{pixel_byte: 8'h00, bad_filter: 1'b1, row_end: 1'b0});
			end else begin
				cur_filter = filter_t'(d[2:0]);
			end
			return;
		end
		idx = (int'(col_cnt) - 1) % STORE_DEPTH;
		a = left_hist[bpp-1];
		c = upleft_hist[bpp-1];
		b = first_row ? 8'h00 : row_mem[idx];
		case (cur_filter)
			FLT_SUB: pred = a;
			FLT_UP: pred = b;
			FLT_AVG: pred = 8'((int'(a) + int'(b)) >> 1);
			FLT_PAETH: pred = paeth_choose(a, b, c);
			default: pred = 8'h00;
		endcase
		r = d + pred;
		for (int k = 3; k > 0; k--) begin
			left_hist[k] = left_hist[k-1];
			upleft_hist[k] = upleft_hist[k-1];
		end
		left_hist[0] = r;
		upleft_hist[0] = b;
		row_mem[idx] = r;
		row_written[idx] = 1'b1;
		last = (int'(col_cnt) >= len);
		if (last) begin
			col_cnt = '0;
			first_row = 1'b0;
		end else begin
			col_cnt = col_cnt + LINE_BYTES_W'(1);
		end
		pixel_q.push_back('{pixel_byte: r, bad_filter: 1'b0, row_end: last});
	endfunction

	// Hold each beat until accepted; drop valid only for a burst gap.
	task automatic send_beat(input logic [7:0] d, input logic st);
		logic start_bit;
		int gap;
		if (tx_idle_en) begin
			if (burst_left == 0) begin
				gap = $urandom_range(0, 6);
				burst_left = $urandom_range(1, 12);
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
		end
		start_bit = st;
		if (!st && col_cnt != 0 && !first_row
				&& !row_written[(int'(col_cnt) - 1) % STORE_DEPTH]) begin
			start_bit = 1'b1;
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tuser <= start_bit;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		unfilter_beat(d, start_bit);
		beats_sent++;
	endtask

	task automatic send_row(input logic [7:0] ftype, input logic st, input int n,
			input bit rand_data);
		logic [7:0] d;
		send_beat(ftype, st);
		for (int k = 0; k < n; k++) begin
			d = rand_data ? 8'($urandom) : ({8{k[0]}} ^ {k[1], 7'h00});
			send_beat(d, 1'b0);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_LINE_BYTES) begin
			cfg_len = val[LINE_BYTES_W-1:0];
		end else begin
			cfg_bpp = val[BPP_W-1:0];
		end
		reg_writes++;
	endtask

	always @(posedge clk) begin
		if (!rx_stall_en) begin
			m_tready <= 1'b1;
		end else begin
			if (stall_pos == 0) begin
				stall_mask = ($urandom_range(0, 7) == 0) ? 32'h0 : $urandom() | $urandom();
			end
			m_tready <= stall_mask[stall_pos];
			stall_pos = (stall_pos + 1) % 32;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (m_tlast) rows_seen++;
			if (m_tuser) bad_seen++;
			if (pixel_q.size() == 0) begin
				$error("unexpected beat: pixel_byte %02h bad_filter %0b row_end %0b",
					m_tdata, m_tuser, m_tlast);
				err_cnt++;
			end else begin
				want = pixel_q.pop_front();
				if (m_tdata !== want.pixel_byte) begin
					$error("pixel_byte: expected %02h, got %02h", want.pixel_byte, m_tdata);
					err_cnt++;
				end
				if (m_tuser !== want.bad_filter) begin
					$error("bad_filter: expected %0b, got %0b", want.bad_filter, m_tuser);
					err_cnt++;
				end
				if (m_tlast !== want.row_end) begin
					$error("row_end: expected %0b, got %0b", want.row_end, m_tlast);
					err_cnt++;
				end
			end
		end
	end

	task automatic test_filter_kinds();
		tx_idle_en = 1'b0;
		rx_stall_en = 1'b0;
		send_row(FLT_NONE, 1'b1, 4, 1'b0);
		send_row(FLT_SUB, 1'b0, 4, 1'b0);
		send_row(FLT_UP, 1'b0, 4, 1'b0);
		send_row(FLT_AVG, 1'b0, 4, 1'b0);
		send_row(FLT_PAETH, 1'b0, 4, 1'b0);
		send_row(BAD_FLT_MAX, 1'b0, 4, 1'b0);
		tx_idle_en = 1'b1;
		rx_stall_en = 1'b1;
	endtask

	task automatic test_register_limits();
		write_reg(REG_LINE_BYTES, '0);
		write_reg(REG_BPP, '0);
		send_row(FLT_SUB, 1'b1, 1, 1'b1);
		send_row(FLT_UP, 1'b0, 1, 1'b1);
		send_row(FLT_PAETH, 1'b0, 1, 1'b1);
		write_reg(REG_LINE_BYTES, 13'd6);
		write_reg(REG_BPP, 13'd7);
		send_row(FLT_AVG, 1'b1, 6, 1'b1);
		send_row(FLT_PAETH, 1'b0, 6, 1'b1);
		write_reg(REG_BPP, 13'd5);
		send_row(FLT_SUB, 1'b0, 6, 1'b1);
		write_reg(REG_LINE_BYTES, 13'd1);
		write_reg(REG_BPP, 13'd1);
		send_row(FLT_PAETH, 1'b0, 1, 1'b1);
		write_reg(REG_LINE_BYTES, 13'h1FFF);
		send_row(FLT_SUB, 1'b1, 30, 1'b1);
	endtask

	task automatic test_image_restart();
		write_reg(REG_LINE_BYTES, 13'd5);
		write_reg(REG_BPP, 13'd3);
		send_row(FLT_NONE, 1'b1, 5, 1'b1);
		send_row(FLT_UP, 1'b0, 2, 1'b1);
		send_row(FLT_PAETH, 1'b1, 5, 1'b1);
		send_row(BAD_FLT_MIN, 1'b0, 5, 1'b1);
		send_row(FLT_AVG, 1'b0, 3, 1'b1);
		send_row(8'hFE, 1'b1, 5, 1'b1);
		send_row(FLT_UP, 1'b0, 5, 1'b1);
	endtask

	task automatic test_long_row();
		write_reg(REG_LINE_BYTES, 13'(LONG_ROW));
		write_reg(REG_BPP, 13'd4);
		send_row(FLT_UP, 1'b1, LONG_ROW, 1'b1);
		send_row(FLT_PAETH, 1'b0, 20, 1'b1);
		// shorten the row in flight: it ends on the next beat
		write_reg(REG_LINE_BYTES, 13'd8);
		send_beat(8'($urandom), 1'b0);
		send_row(FLT_AVG, 1'b0, 8, 1'b1);
		write_reg(REG_BPP, 13'd2);
		send_row(FLT_PAETH, 1'b0, 8, 1'b1);
	endtask

	task automatic test_random_traffic(input int total);
		int done;
		int n;
		int pick;
		logic [7:0] d;
		logic st;
		done = 0;
		while (done < total) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				write_reg(REG_LINE_BYTES, 13'($urandom_range(1, 8)));
			end else if (pick < 85) begin
				write_reg(REG_LINE_BYTES, 13'($urandom_range(9, 40)));
			end else if (pick < 92) begin
				write_reg(REG_LINE_BYTES, '0);
			end else if (pick < 98) begin
				write_reg(REG_LINE_BYTES, 13'($urandom_range(41, 200)));
			end else begin
				write_reg(REG_LINE_BYTES, 13'($urandom_range(STORE_DEPTH + 1, 8191)));
			end
			write_reg(REG_BPP, 13'($urandom_range(0, 7)));
			tx_idle_en = ($urandom_range(0, 3) != 0);
			rx_stall_en = ($urandom_range(0, 3) != 0);
			n = $urandom_range(50, 120);
			for (int k = 0; k < n; k++) begin
				if (col_cnt == 0) begin
					d = ($urandom_range(0, 9) == 0)
						? 8'($urandom_range(BAD_FLT_MIN, BAD_FLT_MAX))
						: 8'($urandom_range(FLT_NONE, FLT_PAETH));
					st = ($urandom_range(0, 11) == 0);
				end else begin
					d = 8'($urandom);
					st = 1'b0;
				end
				if ($urandom_range(0, 99) < 3) st = 1'b1;
				send_beat(d, st);
			end
			done += n;
		end
	endtask

	initial begin
		unfilter_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_filter_kinds();
		test_register_limits();
		test_image_restart();
		test_long_row();
		test_random_traffic(RANDOM_BEATS);
		wait_drained();
		$display("covered: %0d input beats, %0d register writes, all filter types and limits",
			beats_sent, reg_writes);
		$display("checked: %0d output beats, %0d row ends, %0d unknown filter types, %0d errors",
			results_seen, rows_seen, bad_seen, err_cnt);
		if (err_cnt == 0 && pixel_q.size() == 0) begin
			$display("png_scanline_unfilter_top regression: pass");
		end else begin
			$display("png_scanline_unfilter_top regression: fail");
		end
		$finish;
	end

endmodule
